>>> design/alm_pkg.sv
// Shared constants, codes and the sample scaling function for the latency meter.
`default_nettype none

package alm_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ATTENUATE_ON = 1'd1;

  localparam logic [15:0] PULSE_LENGTH_RESET = 16'd64;
  localparam logic        ATTENUATE_RESET    = 1'b1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_START  = 1'b1;

  localparam logic signed [15:0] FULL_SCALE = 16'sd32767;

  // Bits of the multiplier consumed per cycle by the serial multiply unit.
  localparam int DIGIT_W = 4;

  // Division by five through a reciprocal: floor(t / 5) == (t * 209716) >> 20
  // holds for every t below 2^18.
  localparam logic [17:0] SCALE_RECIP = 18'd209716;
  localparam int          SCALE_SHIFT = 20;
  localparam logic [15:0] SCALE_BIAS  = 16'd6554;

  // Scales a Q1.15 sample by 0.2, rounded to nearest.
  function automatic logic signed [15:0] scale_fifth(input logic signed [15:0] s);
    logic [16:0] t;
    logic [34:0] prod;
    logic [14:0] q;
    // s + 32768 is the sample with its sign bit flipped; add 4 more for the rounding.
    t    = {1'b0, ~s[15], s[14:0]} + 17'd4;
    prod = 35'(t) * 35'(SCALE_RECIP);
    q    = prod[SCALE_SHIFT +: 15];
    return $signed({1'b0, q} - SCALE_BIAS);
  endfunction

endpackage

`default_nettype wire

>>> design/alm_ram.sv
// Generic simple dual-port RAM with a registered read port.
`default_nettype none

module alm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/audio_loop_latency_meter.sv
// Round-trip audio latency meter: test pulse generator and windowed peak detector.
//
// Input beats carry a kind bit and a left/right Q1.15 sample pair; every input
// beat yields exactly one output beat with the output samples, the peak flag,
// the latched latency and the armed flag. A start beat arms calibration, loads
// the pulse counter and empties the sample window.
// Timing: a start beat or an unarmed sample beat goes from the idle state straight to
// the finish state, which loads the output register; the next beat is taken once the
// meter is idle again. An armed sample beat runs its products through one 4-bit
// digit-serial multiplier: each product steps through the multiplier digits until no
// nonzero digit is left, then through a step state. A beat needs three products when
// the detector input is not above the window mean and eight otherwise, and no new
// beat is taken until its result is in the output register.
// The output register holds a finished result while the receiver stalls, and the
// next input beat is taken meanwhile; that beat then waits for the register.
// Reset clears the configuration to its defaults, disarms the meter and empties
// the window; the window memory needs no clearing pass, since a fill count marks
// which entries were written since the last start.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none

module audio_loop_latency_meter #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,

  input  wire logic                               cfg_we,
  input  wire logic [alm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [alm_pkg::CFG_DATA_W-1:0]     cfg_data,

  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_kind,
  input  wire logic signed [15:0]                 in_left_in,
  input  wire logic signed [15:0]                 in_right_in,

  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [15:0]                      out_left_out,
  output logic signed [15:0]                      out_right_out,
  output logic                                    out_latency_valid,
  output logic [31:0]                             out_latency_samples,
  output logic                                    out_armed
);

  import alm_pkg::*;

  localparam int LW  = $clog2(WINDOW_DEPTH);
  localparam int SW  = 16 + LW;          // window sum, signed
  localparam int QW  = 31 + LW;          // window sum of squares
  localparam int DW  = 17 + LW;          // N*x - sum
  localparam int MW  = DW;               // multiplier operand
  localparam int PW  = 39 + 3 * LW;      // products and compare operands
  localparam int WPW = $clog2(WINDOW_DEPTH);
  localparam int FW  = $clog2(WINDOW_DEPTH + 1);

  localparam logic [MW-1:0]  N_M      = MW'(WINDOW_DEPTH);
  localparam logic [MW-1:0]  NM1_M    = MW'(WINDOW_DEPTH - 1);
  localparam logic [MW-1:0]  N100_M   = MW'(100 * WINDOW_DEPTH);
  localparam logic [FW-1:0]  FILL_MAX = FW'(WINDOW_DEPTH);
  localparam logic [WPW-1:0] POS_LAST = WPW'(WINDOW_DEPTH - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_STEP, ST_FINISH} state_t;

  // Products in evaluation order: N*x, S*S, N*Q, d*d, dd*(N-1), var*100N,
  // then the squares of the new and the retired window sample.
  typedef enum logic [2:0] {OP_NX, OP_SS, OP_NQ, OP_DD, OP_L, OP_R, OP_XX, OP_OO} op_t;

  state_t state_r;
  op_t    op_r;

  logic [15:0]        pulse_length_r;
  logic               attenuate_r;

  logic               calibrating_r;
  logic [15:0]        pulse_left_r;
  logic [31:0]        lag_r;
  logic [31:0]        measured_r;
  logic [WPW-1:0]     write_pos_r;
  logic [FW-1:0]      fill_r;
  logic signed [SW-1:0] sum_r;
  logic [QW-1:0]      sq_r;

  logic               start_r;
  logic               cal_r;
  logic               peak_r;
  logic signed [15:0] x_r;
  logic signed [15:0] y_r;

  logic [PW-1:0]      acc_r;
  logic [PW-1:0]      mcand_r;
  logic [MW-1:0]      mplier_r;
  logic [DW-1:0]      d_r;
  logic [PW-1:0]      tmp_r;
  logic [PW-1:0]      lhs_r;

  logic               out_valid_r;
  logic signed [15:0] out_left_r;
  logic signed [15:0] out_right_r;
  logic               out_latency_valid_r;
  logic [31:0]        out_latency_samples_r;
  logic               out_armed_r;

  logic signed [15:0] lin_scaled;
  logic signed [15:0] rin_scaled;
  logic [PW+DIGIT_W-1:0] pp_full;
  logic [PW-1:0]      sum_ext;
  logic [SW-1:0]      sum_mag;
  logic [PW-1:0]      d_full;
  logic               d_pos;
  logic [15:0]        x_mag;
  logic [15:0]        ram_rd;
  logic signed [15:0] old_val;
  logic [15:0]        old_mag;
  logic               out_free;
  logic               out_load;
  logic               ram_we;
  logic [31:0]        lag_inc;

  op_t                step_op;
  logic [PW-1:0]      step_mcand;
  logic [MW-1:0]      step_mplier;
  logic               step_done;

  assign lin_scaled = attenuate_r ? scale_fifth(in_left_in)  : in_left_in;
  assign rin_scaled = attenuate_r ? scale_fifth(in_right_in) : in_right_in;

  assign pp_full = mcand_r * mplier_r[DIGIT_W-1:0];

  assign sum_ext = PW'(sum_r);
  assign sum_mag = sum_r[SW-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
  assign d_full  = acc_r - sum_ext;
  assign d_pos   = !d_full[PW-1] && (d_full != '0);
  assign x_mag   = x_r[15] ? $unsigned(-x_r) : $unsigned(x_r);

  // Entries not written since the last start read as zero.
  assign old_val = (fill_r == FILL_MAX) ? $signed(ram_rd) : 16'sd0;
  assign old_mag = old_val[15] ? $unsigned(-old_val) : $unsigned(old_val);

  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == ST_FINISH) && out_free;
  assign ram_we   = (state_r == ST_FINISH) && out_free && cal_r;
  assign lag_inc  = (&lag_r) ? lag_r : lag_r + 32'd1;

  alm_ram #(
    .WIDTH(16),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_pos_r),
    .wdata(x_r),
    .raddr(write_pos_r),
    .rdata(ram_rd)
  );

  // Operands of the next product once the current one is complete.
  always_comb begin
    step_op     = op_r;
    step_mcand  = '0;
    step_mplier = '0;
    step_done   = 1'b0;
    case (op_r)
      OP_NX: begin
        if (d_pos) begin
          step_op     = OP_SS;
          step_mcand  = PW'(sum_mag);
          step_mplier = MW'(sum_mag);
        end else begin
          step_op     = OP_XX;
          step_mcand  = PW'(x_mag);
          step_mplier = MW'(x_mag);
        end
      end
      OP_SS: begin
        step_op     = OP_NQ;
        step_mcand  = PW'(sq_r);
        step_mplier = N_M;
      end
      OP_NQ: begin
        step_op     = OP_DD;
        step_mcand  = PW'(d_r);
        step_mplier = d_r;
      end
      OP_DD: begin
        step_op     = OP_L;
        step_mcand  = acc_r;
        step_mplier = NM1_M;
      end
      OP_L: begin
        step_op     = OP_R;
        step_mcand  = tmp_r;
        step_mplier = N100_M;
      end
      OP_R: begin
        step_op     = OP_XX;
        step_mcand  = PW'(x_mag);
        step_mplier = MW'(x_mag);
      end
      OP_XX: begin
        step_op     = OP_OO;
        step_mcand  = PW'(old_mag);
        step_mplier = MW'(old_mag);
      end
      default: begin
        step_done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= ST_IDLE;
      op_r                <= OP_NX;
      pulse_length_r      <= PULSE_LENGTH_RESET;
      attenuate_r         <= ATTENUATE_RESET;
      calibrating_r       <= 1'b0;
      pulse_left_r        <= '0;
      lag_r               <= '0;
      measured_r          <= '0;
      write_pos_r         <= '0;
      fill_r              <= '0;
      sum_r               <= '0;
      sq_r                <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PULSE_LENGTH: pulse_length_r <= cfg_data;
          CFG_ATTENUATE_ON: attenuate_r    <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            start_r <= (in_kind == KIND_START);
            cal_r   <= (in_kind == KIND_SAMPLE) && calibrating_r;
            x_r     <= lin_scaled;
            y_r     <= rin_scaled;
            peak_r  <= 1'b0;
            if ((in_kind == KIND_SAMPLE) && calibrating_r) begin
              op_r     <= OP_NX;
              mcand_r  <= PW'(lin_scaled);
              mplier_r <= N_M;
              acc_r    <= '0;
              state_r  <= ST_MUL;
            end else begin
              state_r  <= ST_FINISH;
            end
          end
        end

        ST_MUL: begin
          if (mplier_r == '0) begin
            state_r <= ST_STEP;
          end else begin
            acc_r    <= acc_r + pp_full[PW-1:0];
            mcand_r  <= mcand_r << DIGIT_W;
            mplier_r <= mplier_r >> DIGIT_W;
          end
        end

        ST_STEP: begin
          case (op_r)
            OP_NX: d_r    <= d_full[DW-1:0];
            OP_SS: tmp_r  <= acc_r;
            // Clamp the variance term at zero.
            OP_NQ: tmp_r  <= (acc_r > tmp_r) ? acc_r - tmp_r : '0;
            OP_L:  lhs_r  <= acc_r;
            OP_R:  peak_r <= (lhs_r > acc_r);
            OP_XX: tmp_r  <= acc_r;
            default: ;
          endcase
          if (step_done) begin
            state_r <= ST_FINISH;
          end else begin
            op_r     <= step_op;
            mcand_r  <= step_mcand;
            mplier_r <= step_mplier;
            acc_r    <= '0;
            state_r  <= ST_MUL;
          end
        end

        ST_FINISH: begin
          if (out_free) begin
            state_r             <= ST_IDLE;
            out_latency_valid_r <= cal_r && peak_r;
            if (start_r) begin
              calibrating_r         <= 1'b1;
              pulse_left_r          <= pulse_length_r;
              fill_r                <= '0;
              sum_r                 <= '0;
              sq_r                  <= '0;
              out_left_r            <= 16'sd0;
              out_right_r           <= 16'sd0;
              out_latency_samples_r <= measured_r;
              out_armed_r           <= 1'b1;
            end else if (cal_r) begin
              // Here tmp_r holds the new sample squared and acc_r the retired one squared.
              sum_r       <= sum_r + SW'(x_r) - SW'(old_val);
              sq_r        <= sq_r + QW'(tmp_r) - QW'(acc_r);
              write_pos_r <= (write_pos_r == POS_LAST) ? '0 : write_pos_r + WPW'(1);
              if (fill_r != FILL_MAX) begin
                fill_r <= fill_r + FW'(1);
              end
              if (peak_r) begin
                measured_r            <= lag_inc;
                calibrating_r         <= 1'b0;
                out_latency_samples_r <= lag_inc;
                out_armed_r           <= 1'b0;
              end else begin
                out_latency_samples_r <= measured_r;
                out_armed_r           <= 1'b1;
              end
              // The lag counter is held at the pulse length while the pulse runs.
              if (pulse_left_r != '0) begin
                pulse_left_r <= pulse_left_r - 16'd1;
                lag_r        <= {16'd0, pulse_length_r};
                out_left_r   <= FULL_SCALE;
                out_right_r  <= FULL_SCALE;
              end else begin
                lag_r        <= lag_inc;
                out_left_r   <= 16'sd0;
                out_right_r  <= 16'sd0;
              end
            end else begin
              out_left_r            <= x_r;
              out_right_r           <= y_r;
              out_latency_samples_r <= measured_r;
              out_armed_r           <= calibrating_r;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_left_out        = out_left_r;
  assign out_right_out       = out_right_r;
  assign out_latency_valid   = out_latency_valid_r;
  assign out_latency_samples = out_latency_samples_r;
  assign out_armed           = out_armed_r;

endmodule

`default_nettype wire
